FILE: rtl/otq_pkg.sv
// Shared types and codes of the ordered timer queue.
package otq_pkg;

  localparam int unsigned TimeW   = 56;
  localparam int unsigned PeriodW = 40;
  localparam int unsigned TagW    = 32;
  localparam int unsigned MaxOut  = 16;
  localparam int unsigned ResIdxW = 4;
  localparam int unsigned ResCntW = 5;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [2:0] KIND_ADDED    = 3'd0;
  localparam logic [2:0] KIND_REJECTED = 3'd1;
  localparam logic [2:0] KIND_CANCEL   = 3'd2;
  localparam logic [2:0] KIND_EXPIRED  = 3'd3;
  localparam logic [2:0] KIND_NONE     = 3'd4;

  typedef struct packed {
    logic [TimeW-1:0]   expiry;
    logic [PeriodW-1:0] period;
    logic [TagW-1:0]    tag;
  } entry_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [3:0]      slot;
    logic [TagW-1:0] tag;
    logic            ec;
    logic            cf;
  } res_t;

endpackage

FILE: rtl/ordered_timer_queue.sv
// Top level of the ordered timer queue: sequencer, valid bits and output register.
//
// Input beats (in_valid_i/in_ready_o) carry an add, a cancel or a tick; output
// beats (out_valid_o/out_ready_i) carry the results. The block works on one
// item at a time. Deadlines, periods and tags live in a table memory with one
// write port and one registered read port; every search is a sweep over the
// table, one slot a cycle. An add takes one sweep and a write step; a cancel
// takes a lookup (read, then check) and one sweep for the new earliest
// deadline. A tick takes one sweep and one write-back per expired timer, then
// a sweep that finds nothing due (left out once sixteen have expired) and one
// final sweep. Each item is accepted in the idle state. The results of an
// item are collected in a buffer and then delivered at one beat a cycle while
// the receiver is ready, each carrying the earliest deadline after the whole
// item. A stalled receiver holds the output register; the next item is taken
// as soon as the block is idle, even while the last result still waits.
// Reset clears all valid bits and the tag counter; the table contents need no
// clearing.
module ordered_timer_queue #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 mode_i,
  input  logic [otq_pkg::TimeW-1:0]  when_time_i,
  input  logic [otq_pkg::PeriodW-1:0] interval_us_i,
  input  logic [3:0]                 target_slot_i,
  input  logic [otq_pkg::TagW-1:0]   target_tag_i,
  input  logic [otq_pkg::TimeW-1:0]  now_time_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 result_kind_o,
  output logic [3:0]                 out_slot_o,
  output logic [otq_pkg::TagW-1:0]   out_tag_o,
  output logic                       became_first_o,
  output logic                       cancel_found_o,
  output logic                       next_valid_o,
  output logic [otq_pkg::TimeW-1:0]  next_deadline_o,
  output logic                       last_o
);
  import otq_pkg::*;

  localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(TIMER_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_ADD_WR, ST_CAN_RD, ST_CAN_CHK, ST_TICK_WR, ST_EMIT
  } state_e;

  state_e state_q;

  // Control state.
  logic                  iss_q, rd_v_q, end_q, scan_due_q;
  logic                  best_any_q, free_found_q;
  logic [TIMER_SLOTS-1:0] valid_q, done_q;
  logic [TagW-1:0]       tag_ctr_q;
  logic [ResCntW-1:0]    cnt_q;
  logic [ResIdxW-1:0]    emit_idx_q;
  logic                  out_valid_q;

  // Datapath registers.
  logic [1:0]            op_q;
  logic [TimeW-1:0]      when_q, now_q;
  logic [PeriodW-1:0]    per_q;
  logic [3:0]            tslot_q;
  logic [TagW-1:0]       ttag_q;
  logic                  trange_q;
  logic [IW-1:0]         addr_q, rd_idx_q, free_idx_q, best_idx_q;
  logic [TimeW-1:0]      best_time_q;
  logic [PeriodW-1:0]    best_per_q;
  logic [TagW-1:0]       best_tag_q;
  logic                  nv_q;
  logic [TimeW-1:0]      nd_q;
  res_t                  out_res_q;
  logic                  out_nv_q, out_last_q;
  logic [TimeW-1:0]      out_nd_q;

  // Memory and buffer connections.
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr, mem_raddr, taddr;
  entry_t                mem_wdata, rdata;
  logic                  rb_we;
  logic [ResIdxW-1:0]    rb_raddr;
  res_t                  rb_wdata, rb_rdata;

  logic                  accept, cand, better, is_free, add_ec, can_hit, emit_load, emit_last;
  logic [TimeW:0]        rearm_sum;
  logic [TimeW-1:0]      rearm_time;
  logic [TagW-1:0]       tag_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign taddr      = IW'(tslot_q);
  assign tag_next   = tag_ctr_q + TagW'(1);

  // Candidate selection on the word that returns from the table.
  always_comb begin
    if (scan_due_q) begin
      cand = valid_q[rd_idx_q] && !done_q[rd_idx_q] && (rdata.expiry <= now_q);
    end else begin
      cand = valid_q[rd_idx_q];
    end
    better  = rd_v_q && cand && (!best_any_q || (rdata.expiry < best_time_q));
    is_free = rd_v_q && !valid_q[rd_idx_q] && !free_found_q;
  end

  assign add_ec     = !best_any_q || (when_q < best_time_q);
  assign can_hit    = trange_q && valid_q[taddr] && (rdata.tag == ttag_q);
  assign rearm_sum  = {1'b0, now_q} + {{(TimeW + 1 - PeriodW){1'b0}}, best_per_q};
  assign rearm_time = rearm_sum[TimeW] ? {TimeW{1'b1}} : rearm_sum[TimeW-1:0];
  assign emit_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign emit_last  = (ResCntW'(emit_idx_q) + ResCntW'(1)) == cnt_q;
  // The buffer read runs one beat ahead so that the next beat is ready on load.
  assign rb_raddr   = (emit_load && !emit_last) ? emit_idx_q + ResIdxW'(1) : emit_idx_q;

  // Table accesses and result writes.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx_q;
    mem_wdata = '{expiry: rearm_time, period: best_per_q, tag: best_tag_q};
    mem_raddr = (state_q == ST_CAN_RD) ? taddr : addr_q;
    rb_we     = 1'b0;
    rb_wdata  = '{kind: KIND_NONE, slot: 4'd0, tag: '0, ec: 1'b0, cf: 1'b0};
    case (state_q)
      ST_ADD_WR: begin
        rb_we = 1'b1;
        if (free_found_q) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx_q;
          mem_wdata = '{expiry: when_q, period: per_q, tag: tag_next};
          rb_wdata  = '{kind: KIND_ADDED, slot: 4'(free_idx_q), tag: tag_next,
                        ec: add_ec, cf: 1'b0};
        end else begin
          rb_wdata  = '{kind: KIND_REJECTED, slot: 4'd0, tag: '0, ec: 1'b0, cf: 1'b0};
        end
      end
      ST_CAN_CHK: begin
        rb_we    = 1'b1;
        rb_wdata = '{kind: KIND_CANCEL, slot: tslot_q, tag: ttag_q, ec: 1'b0, cf: can_hit};
      end
      ST_TICK_WR: begin
        mem_we   = (best_per_q != '0);
        rb_we    = 1'b1;
        rb_wdata = '{kind: KIND_EXPIRED, slot: 4'(best_idx_q), tag: best_tag_q,
                     ec: 1'b0, cf: 1'b0};
      end
      ST_SCAN: begin
        // A tick that found nothing due reports so in a single beat.
        rb_we = end_q && scan_due_q && !best_any_q && (cnt_q == '0);
      end
      default: ;
    endcase
  end

  otq_mem #(.Depth(TIMER_SLOTS), .AddrW(IW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  otq_rbuf u_rbuf (
    .clk_i   (clk_i),
    .we_i    (rb_we),
    .waddr_i (cnt_q[ResIdxW-1:0]),
    .wdata_i (rb_wdata),
    .raddr_i (rb_raddr),
    .rdata_o (rb_rdata)
  );

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      iss_q        <= 1'b0;
      rd_v_q       <= 1'b0;
      end_q        <= 1'b0;
      scan_due_q   <= 1'b0;
      best_any_q   <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      done_q       <= '0;
      tag_ctr_q    <= '0;
      cnt_q        <= '0;
      emit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q        <= '0;
            emit_idx_q   <= '0;
            done_q       <= '0;
            best_any_q   <= 1'b0;
            free_found_q <= 1'b0;
            iss_q        <= 1'b1;
            rd_v_q       <= 1'b0;
            end_q        <= 1'b0;
            scan_due_q   <= (mode_i == MODE_TICK);
            case (mode_i)
              MODE_ADD:    state_q <= ST_SCAN;
              MODE_CANCEL: state_q <= ST_CAN_RD;
              MODE_TICK:   state_q <= ST_SCAN;
              default:     state_q <= ST_IDLE;
            endcase
          end
        end
        ST_CAN_RD: state_q <= ST_CAN_CHK;
        ST_CAN_CHK: begin
          if (can_hit) begin
            valid_q[taddr] <= 1'b0;
          end
          cnt_q      <= ResCntW'(1);
          scan_due_q <= 1'b0;
          state_q    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (end_q) begin
            iss_q  <= 1'b1;
            rd_v_q <= 1'b0;
            end_q  <= 1'b0;
            if (scan_due_q) begin
              if (best_any_q) begin
                state_q <= ST_TICK_WR;
              end else begin
                if (cnt_q == '0) begin
                  cnt_q <= ResCntW'(1);
                end
                scan_due_q <= 1'b0;
                best_any_q <= 1'b0;
              end
            end else if (op_q == MODE_ADD) begin
              state_q <= ST_ADD_WR;
            end else begin
              state_q <= ST_EMIT;
            end
          end else begin
            rd_v_q <= iss_q;
            if (iss_q && (addr_q == LastIdx)) begin
              iss_q <= 1'b0;
            end
            end_q <= rd_v_q && (rd_idx_q == LastIdx);
            if (better) begin
              best_any_q <= 1'b1;
            end
            if (is_free) begin
              free_found_q <= 1'b1;
            end
          end
        end
        ST_ADD_WR: begin
          if (free_found_q) begin
            valid_q[free_idx_q] <= 1'b1;
            tag_ctr_q           <= tag_next;
          end
          cnt_q   <= ResCntW'(1);
          state_q <= ST_EMIT;
        end
        ST_TICK_WR: begin
          done_q[best_idx_q] <= 1'b1;
          if (best_per_q == '0) begin
            valid_q[best_idx_q] <= 1'b0;
          end
          cnt_q      <= cnt_q + ResCntW'(1);
          best_any_q <= 1'b0;
          // After the sixteenth expiry the rest wait for the next tick.
          if ((cnt_q + ResCntW'(1)) == ResCntW'(MaxOut)) begin
            scan_due_q <= 1'b0;
          end
          state_q <= ST_SCAN;
        end
        ST_EMIT: begin
          if (emit_load) begin
            if (emit_last) begin
              state_q <= ST_IDLE;
            end else begin
              emit_idx_q <= emit_idx_q + ResIdxW'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= mode_i;
      when_q   <= when_time_i;
      per_q    <= interval_us_i;
      tslot_q  <= target_slot_i;
      ttag_q   <= target_tag_i;
      trange_q <= (32'(target_slot_i) < TIMER_SLOTS);
      now_q    <= now_time_i;
    end
    if (state_q != ST_SCAN || end_q) begin
      addr_q <= '0;
    end else if (iss_q && (addr_q != LastIdx)) begin
      addr_q <= addr_q + IW'(1);
    end
    rd_idx_q <= addr_q;
    if (better) begin
      best_time_q <= rdata.expiry;
      best_idx_q  <= rd_idx_q;
      best_per_q  <= rdata.period;
      best_tag_q  <= rdata.tag;
    end
    if (is_free) begin
      free_idx_q <= rd_idx_q;
    end
    if (state_q == ST_ADD_WR) begin
      nv_q <= free_found_q || best_any_q;
      if (free_found_q && add_ec) begin
        nd_q <= when_q;
      end else begin
        nd_q <= best_any_q ? best_time_q : '0;
      end
    end else if ((state_q == ST_SCAN) && end_q && !scan_due_q && (op_q != MODE_ADD)) begin
      nv_q <= best_any_q;
      nd_q <= best_any_q ? best_time_q : '0;
    end
    if (emit_load) begin
      out_res_q  <= rb_rdata;
      out_nv_q   <= nv_q;
      out_nd_q   <= nd_q;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_res_q.kind;
  assign out_slot_o      = out_res_q.slot;
  assign out_tag_o       = out_res_q.tag;
  assign became_first_o  = out_res_q.ec;
  assign cancel_found_o  = out_res_q.cf;
  assign next_valid_o    = out_nv_q;
  assign next_deadline_o = out_nd_q;
  assign last_o          = out_last_q;

endmodule

FILE: rtl/otq_mem.sv
// Timer table memory: one write port, one registered read port.
module otq_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  otq_pkg::entry_t      wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output otq_pkg::entry_t      rdata_o
);
  import otq_pkg::*;

  entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/otq_rbuf.sv
// Result buffer that holds the beats of one item until its summary is known.
module otq_rbuf (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [otq_pkg::ResIdxW-1:0]   waddr_i,
  input  otq_pkg::res_t                 wdata_i,
  input  logic [otq_pkg::ResIdxW-1:0]   raddr_i,
  output otq_pkg::res_t                 rdata_o
);
  import otq_pkg::*;

  res_t buf_q [MaxOut];

  // A read of the entry being written returns the new beat.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      buf_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_o <= wdata_i;
    end else begin
      rdata_o <= buf_q[raddr_i];
    end
  end

endmodule
